### hdl/hung_task_rate_limited_detector_unit_macros.svh
// Assertion macros for the hung task detector checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HUNG_TASK_RATE_LIMITED_DETECTOR_UNIT_MACROS_SVH
`define HUNG_TASK_RATE_LIMITED_DETECTOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HTRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/htrd_pkg.sv
// Shared constants, codes and structs of the hung task detector.
// No dependencies; used by the interfaces, the slot cell, the top level and the checker.
package htrd_pkg;

    localparam int SLOTS     = 32;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIELD_W   = 64;
    localparam int OUTCOME_W = 3;
    localparam int CFG_IDX_W = 2;

    // result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_IDLE       = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_WARNED     = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_SUPPRESSED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED    = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_CLEARED    = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_DISABLED   = 3'd5;

    // function codes of the input transaction
    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

    // reset values of the registers
    localparam logic [FIELD_W-1:0] THRESHOLD_RST = 64'd3000;
    localparam logic [FIELD_W-1:0] WINDOW_RST    = 64'd6000;

    // lookup token passed from cell to cell
    typedef struct packed {
        logic               vld;
        logic [FIELD_W-1:0] id;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [FIELD_W-1:0] hit_tick;
        logic               free;
        logic [IDX_W-1:0]   free_idx;
    } t_token;

    // update broadcast to every cell
    typedef struct packed {
        logic               wr;
        logic               clr;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] tick;
    } t_slot_wr;

endpackage

### hdl/htrd_in_if.sv
// Input channel of the hung task detector: valid/ready plus one report.
// Depends on htrd_pkg for field widths.
interface htrd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [htrd_pkg::FIELD_W-1:0] task_id;
    logic [htrd_pkg::FIELD_W-1:0] block_start;
    logic [htrd_pkg::FIELD_W-1:0] now;

    modport source (output valid, func, task_id, block_start, now, input ready);
    modport sink   (input valid, func, task_id, block_start, now, output ready);
endinterface

### hdl/htrd_out_if.sv
// Output channel of the hung task detector: valid/ready plus one result.
// Depends on htrd_pkg for field widths.
interface htrd_out_if;
    logic                           valid;
    logic                           ready;
    logic [htrd_pkg::OUTCOME_W-1:0] outcome;
    logic [htrd_pkg::FIELD_W-1:0]   blocked_ticks;
    logic [htrd_pkg::FIELD_W-1:0]   warnings_count;

    modport source (output valid, outcome, blocked_ticks, warnings_count, input ready);
    modport sink   (input valid, outcome, blocked_ticks, warnings_count, output ready);
endinterface

### hdl/hung_task_rate_limited_detector_unit.sv
// Hung task detector with per-id warning rate limit.
// Input channel i_in carries one report per transaction: func (observe or clear),
// task_id, block_start and now. Output channel o_out returns exactly one result per
// report: outcome, blocked_ticks and the running warnings_count.
// Configuration (enabled, threshold, suppress_window) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data. The user must write it only while no report is in flight;
// the block itself does not enforce this. A clear, disabled, future-start,
// below-threshold or id-zero report goes from ST_CALC through ST_CLASS to ST_PUSH.
// Any other report sends a lookup token down the row of SLOTS slot cells, one cell
// per cycle, then passes ST_SCAN and ST_DECIDE before ST_PUSH. One report is taken
// at a time; the next can be accepted in the cycle after ST_PUSH loads the result
// into the output register.
// Reset (synchronous, active low) empties the slot table, zeroes the warning total
// and loads enabled = 1, threshold = 3000, suppress_window = 6000.
// A stalled receiver holds the result in the output register; one more report can
// be taken and worked on meanwhile, and it waits there until the register frees.
// Depends on htrd_pkg, htrd_in_if, htrd_out_if and htrd_cell.
module hung_task_rate_limited_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    htrd_in_if.sink                        i_in,
    htrd_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [htrd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [htrd_pkg::FIELD_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_CLASS,
        ST_SCAN,
        ST_DECIDE,
        ST_PUSH
    } t_state;

    t_state                          r_state;
    logic                            r_enabled;
    logic [htrd_pkg::FIELD_W-1:0]    r_threshold;
    logic [htrd_pkg::FIELD_W-1:0]    r_window;
    logic [htrd_pkg::FIELD_W-1:0]    r_warn_total;

    logic                            r_func;
    logic [htrd_pkg::FIELD_W-1:0]    r_id;
    logic [htrd_pkg::FIELD_W-1:0]    r_start;
    logic [htrd_pkg::FIELD_W-1:0]    r_now;
    logic [htrd_pkg::FIELD_W-1:0]    r_stuck;
    logic                            r_future;
    htrd_pkg::t_token                r_tok;

    logic [htrd_pkg::OUTCOME_W-1:0]  r_res_outcome;
    logic [htrd_pkg::FIELD_W-1:0]    r_res_stuck;

    logic                            r_out_valid;
    logic [htrd_pkg::OUTCOME_W-1:0]  r_out_outcome;
    logic [htrd_pkg::FIELD_W-1:0]    r_out_stuck;
    logic [htrd_pkg::FIELD_W-1:0]    r_out_count;

    logic [htrd_pkg::FIELD_W:0]      w_diff;
    logic                            w_below;
    logic                            w_scan;
    logic [htrd_pkg::FIELD_W-1:0]    w_age;
    logic                            w_suppress;
    logic                            w_warn;
    logic                            w_out_free;
    htrd_pkg::t_slot_wr              w_wr;
    htrd_pkg::t_token                w_tok [htrd_pkg::SLOTS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_threshold <= htrd_pkg::THRESHOLD_RST;
            r_window    <= htrd_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                htrd_pkg::CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                htrd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                htrd_pkg::CFG_WINDOW:    r_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stuck time with borrow; borrow set means the start lies in the future
    assign w_diff  = {1'b0, r_now} - {1'b0, r_start};
    assign w_below = (r_stuck < r_threshold);
    assign w_scan  = (r_state == ST_CLASS) && (r_func == htrd_pkg::FUNC_OBSERVE) &&
                     r_enabled && !r_future && !w_below && (r_id != '0);

    // suppression test on the matched slot, modulo 2^64
    assign w_age      = r_now - r_tok.hit_tick;
    assign w_suppress = r_tok.hit && (w_age < r_window);
    assign w_warn     = !w_suppress && (r_tok.hit || r_tok.free);
    assign w_out_free = !r_out_valid || o_out.ready;

    // table update broadcast
    always_comb begin
        w_wr.clr  = (r_state == ST_CLASS) && (r_func == htrd_pkg::FUNC_CLEAR);
        w_wr.wr   = (r_state == ST_DECIDE) && w_warn;
        w_wr.idx  = r_tok.hit ? r_tok.hit_idx : r_tok.free_idx;
        w_wr.id   = r_id;
        w_wr.tick = r_now;
    end

    // token injected into the first cell
    always_comb begin
        w_tok[0].vld      = w_scan;
        w_tok[0].id       = r_id;
        w_tok[0].hit      = 1'b0;
        w_tok[0].hit_idx  = '0;
        w_tok[0].hit_tick = '0;
        w_tok[0].free     = 1'b0;
        w_tok[0].free_idx = '0;
    end

    // row of slot cells
    for (genvar g = 0; g < htrd_pkg::SLOTS; g++) begin : g_cell
        htrd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (htrd_pkg::IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[g+1])
        );
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_warn_total <= '0;
        end else begin
            // output valid: set on a push, dropped once the transaction is taken
            if ((r_state == ST_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_func  <= i_in.func;
                        r_id    <= i_in.task_id;
                        r_start <= i_in.block_start;
                        r_now   <= i_in.now;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_future <= w_diff[htrd_pkg::FIELD_W];
                    r_stuck  <= w_diff[htrd_pkg::FIELD_W] ? '0 : w_diff[htrd_pkg::FIELD_W-1:0];
                    r_state  <= ST_CLASS;
                end
                ST_CLASS: begin
                    if (r_func == htrd_pkg::FUNC_CLEAR) begin
                        r_res_outcome <= htrd_pkg::OUT_CLEARED;
                        r_res_stuck   <= '0;
                        r_state       <= ST_PUSH;
                    end else if (!r_enabled) begin
                        r_res_outcome <= htrd_pkg::OUT_DISABLED;
                        r_res_stuck   <= '0;
                        r_state       <= ST_PUSH;
                    end else if (r_future || w_below) begin
                        r_res_outcome <= htrd_pkg::OUT_IDLE;
                        r_res_stuck   <= r_stuck;
                        r_state       <= ST_PUSH;
                    end else if (r_id == '0) begin
                        r_res_outcome <= htrd_pkg::OUT_DROPPED;
                        r_res_stuck   <= r_stuck;
                        r_state       <= ST_PUSH;
                    end else begin
                        r_res_stuck <= r_stuck;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_tok[htrd_pkg::SLOTS].vld) begin
                        r_tok   <= w_tok[htrd_pkg::SLOTS];
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_suppress) begin
                        r_res_outcome <= htrd_pkg::OUT_SUPPRESSED;
                    end else if (w_warn) begin
                        r_res_outcome <= htrd_pkg::OUT_WARNED;
                        r_warn_total  <= r_warn_total + 1'b1;
                    end else begin
                        r_res_outcome <= htrd_pkg::OUT_DROPPED;
                    end
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (w_out_free) begin
                        r_out_outcome <= r_res_outcome;
                        r_out_stuck   <= r_res_stuck;
                        r_out_count   <= r_warn_total;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.outcome        = r_out_outcome;
    assign o_out.blocked_ticks  = r_out_stuck;
    assign o_out.warnings_count = r_out_count;

endmodule

### hdl/htrd_cell.sv
// One slot of the warned-id table: holds an id and its last warning tick.
// Depends on htrd_pkg (t_token, t_slot_wr); instanced in a row by the top level.
module htrd_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [htrd_pkg::IDX_W-1:0] i_idx,
    input  htrd_pkg::t_token           i_tok,
    input  htrd_pkg::t_slot_wr         i_wr,
    output htrd_pkg::t_token           o_tok
);

    logic [htrd_pkg::FIELD_W-1:0] r_id;
    logic [htrd_pkg::FIELD_W-1:0] r_tick;
    htrd_pkg::t_token             r_tok;
    htrd_pkg::t_token             n_tok;

    // fold this slot into the passing token: first match and first free slot
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && (r_id == i_tok.id)) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = i_idx;
            n_tok.hit_tick = r_tick;
        end
        if (!i_tok.free && (r_id == '0)) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = i_idx;
        end
    end

    // token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // slot contents: cleared together, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= '0;
            r_tick <= '0;
        end else if (i_wr.clr) begin
            r_id   <= '0;
            r_tick <= '0;
        end else if (i_wr.wr && (i_wr.idx == i_idx)) begin
            r_id   <= i_wr.id;
            r_tick <= i_wr.tick;
        end
    end

    assign o_tok = r_tok;

endmodule

### hdl/htrd_checker.sv
// Port-level checker for the hung task detector, bound to the top level.
// Depends on htrd_pkg and hung_task_rate_limited_detector_unit_macros.svh.
`include "hung_task_rate_limited_detector_unit_macros.svh"

module htrd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [htrd_pkg::OUTCOME_W-1:0] i_outcome,
    input logic [htrd_pkg::FIELD_W-1:0]   i_blocked_ticks,
    input logic [htrd_pkg::FIELD_W-1:0]   i_warnings_count
);

    logic                         w_take;
    logic                         w_stall;
    logic                         w_code_ok;
    logic                         w_no_ticks;
    logic [htrd_pkg::FIELD_W-1:0] w_count_want;
    logic [htrd_pkg::OUTCOME_W+2*htrd_pkg::FIELD_W-1:0] w_result;
    logic [htrd_pkg::FIELD_W-1:0] r_last_count;

    assign w_take    = i_out_valid && i_out_ready;
    assign w_stall   = i_out_valid && !i_out_ready;
    assign w_code_ok = (i_outcome <= htrd_pkg::OUT_DISABLED);
    assign w_result  = {i_outcome, i_blocked_ticks, i_warnings_count};

    // clear and disabled results carry no blocked time
    assign w_no_ticks = i_out_valid && ((i_outcome == htrd_pkg::OUT_CLEARED) ||
                                        (i_outcome == htrd_pkg::OUT_DISABLED));

    // total steps by one on a warning, holds otherwise
    assign w_count_want = (i_outcome == htrd_pkg::OUT_WARNED) ? r_last_count + 1'b1
                                                                : r_last_count;

    // warning total seen on the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
        end else if (w_take) begin
            r_last_count <= i_warnings_count;
        end
    end

    `HTRD_ASSERT_NOW(a_outcome_code, i_out_valid, w_code_ok, "outcome code out of range")
    `HTRD_ASSERT_NEXT(a_hold, w_stall, i_out_valid && $stable(w_result), "held result changed")
    `HTRD_ASSERT_NOW(a_zero_ticks, w_no_ticks, i_blocked_ticks == '0, "ticks not zero")
    `HTRD_ASSERT_NOW(a_count_step, w_take, i_warnings_count == w_count_want, "bad warning total")

endmodule

bind hung_task_rate_limited_detector_unit htrd_checker u_htrd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_outcome        (o_out.outcome),
    .i_blocked_ticks  (o_out.blocked_ticks),
    .i_warnings_count (o_out.warnings_count)
);

### test/hung_task_rate_limited_detector_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for hung_task_rate_limited_detector_unit.
// Depends on htrd_pkg, htrd_in_if, htrd_out_if and the detector RTL; a local shadow
// of the slot table predicts every result and a monitor compares them in order.
module hung_task_rate_limited_detector_unit_tb;

    localparam int SLOTS          = htrd_pkg::SLOTS;
    localparam int FIELD_W        = htrd_pkg::FIELD_W;
    localparam int OUTCOME_W      = htrd_pkg::OUTCOME_W;
    localparam int CFG_IDX_W      = htrd_pkg::CFG_IDX_W;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = SLOTS + 8;
    localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};

    typedef struct {
        logic [OUTCOME_W-1:0] outcome;
        logic [FIELD_W-1:0]   blocked_ticks;
        logic [FIELD_W-1:0]   warnings_count;
    } t_verdict;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [FIELD_W-1:0]   cfg_data;

    htrd_in_if  report_ch ();
    htrd_out_if verdict_ch ();

    hung_task_rate_limited_detector_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (report_ch),
        .o_out      (verdict_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow of the detector registers and slot table
    logic               shadow_enabled;
    logic [FIELD_W-1:0] shadow_threshold;
    logic [FIELD_W-1:0] shadow_window;
    logic [FIELD_W-1:0] shadow_slot_id   [SLOTS];
    logic [FIELD_W-1:0] shadow_slot_tick [SLOTS];
    logic [FIELD_W-1:0] shadow_warn_total;

    t_verdict           pending_verdicts [$];
    bit                 failed;
    bit                 calm;
    int                 sink_gap;
    int                 idle_cycles;

    // traffic generator state
    logic [FIELD_W-1:0] tick_now;
    logic [FIELD_W-1:0] tick_step;
    logic [FIELD_W-1:0] task_pool [64];
    int                 pool_size;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_shadow_slots();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_slot_id[i]   = '0;
            shadow_slot_tick[i] = '0;
        end
    endfunction

    // expected result of one report; updates the shadow state
    function automatic t_verdict predict_verdict(logic func, logic [FIELD_W-1:0] id,
                                                 logic [FIELD_W-1:0] start,
                                                 logic [FIELD_W-1:0] cur_tick);
        t_verdict v;
        int       hit;
        int       free_at;
        int       slot;
        v.blocked_ticks = '0;
        hit             = -1;
        free_at         = -1;
        if (func == htrd_pkg::FUNC_CLEAR) begin
            clear_shadow_slots();
            v.outcome = htrd_pkg::OUT_CLEARED;
        end else if (!shadow_enabled) begin
            v.outcome = htrd_pkg::OUT_DISABLED;
        end else if (start > cur_tick) begin
            v.outcome = htrd_pkg::OUT_IDLE;
        end else begin
            v.blocked_ticks = cur_tick - start;
            if (v.blocked_ticks < shadow_threshold) begin
                v.outcome = htrd_pkg::OUT_IDLE;
            end else begin
                // id zero never matches and never takes a slot
                if (id != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && shadow_slot_id[i] == id) hit = i;
                        if (free_at < 0 && shadow_slot_id[i] == '0) free_at = i;
                    end
                end
                if (hit < 0 && free_at < 0) begin
                    v.outcome = htrd_pkg::OUT_DROPPED;
                end else if (hit >= 0 &&
                             (cur_tick - shadow_slot_tick[hit]) < shadow_window) begin
                    v.outcome = htrd_pkg::OUT_SUPPRESSED;
                end else begin
                    slot                   = (hit >= 0) ? hit : free_at;
                    shadow_slot_id[slot]   = id;
                    shadow_slot_tick[slot] = cur_tick;
                    shadow_warn_total      = shadow_warn_total + 1'b1;
                    v.outcome              = htrd_pkg::OUT_WARNED;
                end
            end
        end
        v.warnings_count = shadow_warn_total;
        return v;
    endfunction

    // one report transaction; returns just after the next falling edge, valid still high
    task automatic send_report(logic func, logic [FIELD_W-1:0] id,
                               logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] cur_tick);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            report_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        report_ch.func        <= func;
        report_ch.task_id     <= id;
        report_ch.block_start <= start;
        report_ch.now         <= cur_tick;
        report_ch.valid       <= 1'b1;
        @(posedge i_clk);
        while (!report_ch.ready) @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(func, id, start, cur_tick));
        @(negedge i_clk);
    endtask

    task automatic park_input();
        report_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        park_input();
        while (pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            htrd_pkg::CFG_ENABLED:   shadow_enabled   = data[0];
            htrd_pkg::CFG_THRESHOLD: shadow_threshold = data;
            htrd_pkg::CFG_WINDOW:    shadow_window    = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic set_config(logic en, logic [FIELD_W-1:0] thr, logic [FIELD_W-1:0] win);
        wait_drained();
        write_reg(htrd_pkg::CFG_ENABLED, {{(FIELD_W-1){1'b0}}, en});
        write_reg(htrd_pkg::CFG_THRESHOLD, thr);
        write_reg(htrd_pkg::CFG_WINDOW, win);
    endtask

    // mostly plausible reports from a pool of ids on a running tick, some noise and clears
    task automatic send_random_report();
        int                 pick;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] stuck;
        logic [FIELD_W-1:0] start;
        pick     = $urandom_range(0, 99);
        tick_now = tick_now + rand64() % (tick_step + 1'b1);
        if (pick < 2) begin
            send_report(htrd_pkg::FUNC_CLEAR, rand64(), rand64(), rand64());
        end else if (pick < 12) begin
            send_report(htrd_pkg::FUNC_OBSERVE, rand64(), rand64(), rand64());
        end else begin
            id = ($urandom_range(0, 49) == 0) ? '0 : task_pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 4))
                0:       stuck = shadow_threshold - 1'b1;
                1:       stuck = shadow_threshold;
                2:       stuck = shadow_threshold + $urandom_range(0, 5000);
                3:       stuck = rand64() >> $urandom_range(0, 63);
                default: stuck = shadow_threshold + (rand64() >> 20);
            endcase
            if ($urandom_range(0, 19) == 0) start = tick_now + 1'b1 + $urandom_range(0, 100);
            else                            start = tick_now - stuck;
            send_report(htrd_pkg::FUNC_OBSERVE, id, start, tick_now);
        end
    endtask

    task automatic random_phase(int n_items, logic en, logic [FIELD_W-1:0] thr,
                                logic [FIELD_W-1:0] win, logic [FIELD_W-1:0] step,
                                int n_ids, logic [FIELD_W-1:0] first_tick);
        set_config(en, thr, win);
        tick_step = step;
        tick_now  = first_tick;
        pool_size = n_ids;
        for (int k = 0; k < n_ids; k++) begin
            task_pool[k] = ($urandom_range(0, 1) == 0) ? FIELD_W'(k + 1) : (rand64() | 1'b1);
        end
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            // hold off the sender until every result is back
            if (i == n_items / 2) wait_drained();
            send_random_report();
        end
        calm = 1'b0;
    endtask

    // extremes of the fields and each corner of the decision chain
    task automatic directed_corner_test();
        send_report(htrd_pkg::FUNC_OBSERVE, '0, '0, 64'd5000);         // id zero dropped
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, 64'd101, 64'd100);  // start in the future
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, 64'd1, 64'd3000);   // one tick short
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd3000);      // exactly at threshold
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd8999);      // inside window
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd9000);      // window just expired
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd4000);      // tick went backwards
        send_report(htrd_pkg::FUNC_OBSERVE, ALL_ONES, '0, ALL_ONES);
        send_report(htrd_pkg::FUNC_OBSERVE, ALL_ONES, ALL_ONES, ALL_ONES);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'h8000_0000_0000_0000,
                    64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES);
        send_report(htrd_pkg::FUNC_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd4000);      // fresh slot after clear
        set_config(1'b0, htrd_pkg::THRESHOLD_RST, htrd_pkg::WINDOW_RST);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd7, '0, 64'd100000);    // disabled
        send_report(htrd_pkg::FUNC_CLEAR, '0, '0, '0);                 // clear while disabled
        set_config(1'b1, '0, '0);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd9, 64'd50, 64'd50);    // zero stuck still hung
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd9, 64'd50, 64'd50);    // zero window never quiets
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd9, 64'd51, 64'd50);
        set_config(1'b1, ALL_ONES, ALL_ONES);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd9, '0, ALL_ONES);      // widest window
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd11, '0, ALL_ONES);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'd11, 64'd1, ALL_ONES);
    endtask

    // fill every slot, then a new id must be dropped
    task automatic table_overflow_test();
        set_config(1'b1, '0, ALL_ONES);
        send_report(htrd_pkg::FUNC_CLEAR, '0, '0, '0);
        for (int k = 0; k < SLOTS; k++) begin
            send_report(htrd_pkg::FUNC_OBSERVE, {32'hA5A5_0000, 32'(k + 1)}, '0,
                        FIELD_W'(1000 + k));
        end
        send_report(htrd_pkg::FUNC_OBSERVE, 64'hDEAD_0000_0000_0001, '0, 64'd5000);
        send_report(htrd_pkg::FUNC_OBSERVE, {32'hA5A5_0000, 32'd1}, '0, 64'd6000);
        send_report(htrd_pkg::FUNC_CLEAR, '0, '0, '0);
        send_report(htrd_pkg::FUNC_OBSERVE, 64'hDEAD_0000_0000_0001, '0, 64'd7000);
    endtask

    task automatic steady_traffic_test();
        random_phase(400, 1'b1, htrd_pkg::THRESHOLD_RST, htrd_pkg::WINDOW_RST, 64'd2000, 40,
                     '0);
    endtask

    // zero limits, tick running across the wrap
    task automatic zero_limits_test();
        random_phase(300, 1'b1, '0, '0, 64'd50, 24, 64'hFFFF_FFFF_FFFF_F000);
    endtask

    task automatic random_limits_test();
        random_phase(300, 1'b1, FIELD_W'($urandom_range(1, 100000)),
                     FIELD_W'($urandom_range(1, 200000)), 64'd20000, 36, rand64());
        random_phase(300, 1'b1, 64'd1, rand64() >> 40, 64'd1 << 22, 40, rand64());
    endtask

    task automatic saturated_limits_test();
        random_phase(200, 1'b1, ALL_ONES, ALL_ONES, 64'd1000, 20, rand64());
    endtask

    task automatic disabled_traffic_test();
        random_phase(100, 1'b0, htrd_pkg::THRESHOLD_RST, htrd_pkg::WINDOW_RST, 64'd2000, 16,
                     '0);
    endtask

    // result monitor; also draws the stall before the next result
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result: outcome %0d ticks %h count %h", $time,
                         verdict_ch.outcome, verdict_ch.blocked_ticks,
                         verdict_ch.warnings_count);
                failed = 1'b1;
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict_ch.outcome !== want.outcome) begin
                    $display("%0t: outcome mismatch: expected %0d, got %0d", $time,
                             want.outcome, verdict_ch.outcome);
                    failed = 1'b1;
                end
                if (verdict_ch.blocked_ticks !== want.blocked_ticks) begin
                    $display("%0t: blocked_ticks mismatch: expected %h, got %h", $time,
                             want.blocked_ticks, verdict_ch.blocked_ticks);
                    failed = 1'b1;
                end
                if (verdict_ch.warnings_count !== want.warnings_count) begin
                    $display("%0t: warnings_count mismatch: expected %h, got %h", $time,
                             want.warnings_count, verdict_ch.warnings_count);
                    failed = 1'b1;
                end
            end
            sink_gap = calm ? 0 : $urandom_range(0, 3);
        end
    end

    // receiver ready
    initial begin
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_gap > 0) begin
                verdict_ch.ready <= 1'b0;
                sink_gap = sink_gap - 1;
            end else begin
                verdict_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transaction
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((report_ch.valid && report_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pending_verdicts.size());
        $display("hung_task_rate_limited_detector_unit regression: fail");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = htrd_pkg::CFG_ENABLED;
        cfg_data              = '0;
        report_ch.valid       = 1'b0;
        report_ch.func        = htrd_pkg::FUNC_OBSERVE;
        report_ch.task_id     = '0;
        report_ch.block_start = '0;
        report_ch.now         = '0;
        failed                = 1'b0;
        calm                  = 1'b0;
        sink_gap              = 0;
        tick_now              = '0;
        tick_step             = '0;
        pool_size             = 1;
        shadow_enabled        = 1'b1;
        shadow_threshold      = htrd_pkg::THRESHOLD_RST;
        shadow_window         = htrd_pkg::WINDOW_RST;
        shadow_warn_total     = '0;
        clear_shadow_slots();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_corner_test();
        table_overflow_test();
        steady_traffic_test();
        zero_limits_test();
        random_limits_test();
        saturated_limits_test();
        disabled_traffic_test();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (!failed)
            $display("hung_task_rate_limited_detector_unit regression: pass");
        else
            $display("hung_task_rate_limited_detector_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/htrd_pkg.sv
hdl/htrd_in_if.sv
hdl/htrd_out_if.sv
hdl/htrd_cell.sv
hdl/hung_task_rate_limited_detector_unit.sv
hdl/htrd_checker.sv
test/hung_task_rate_limited_detector_unit_tb.sv
